// ----- src/hsec_pkg.sv -----
// Shared types, constants and functions of the Hamming SEC encoder and checker.
package hsec_pkg;

	localparam int CODE_W            = 64;
	localparam int DATA_W            = 57;
	localparam int LEN_W             = 7;
	localparam int SYN_W             = 7;
	localparam int CFG_W             = 6;
	localparam int APB_DATA_W        = 32;
	localparam int APB_ADDR_W        = 3;
	localparam int MAX_CODE_BITS_DEF = 64;
	localparam int DATA_BITS_LIMIT   = 57;

	localparam logic [CFG_W-1:0] DATA_BITS_RESET = 6'd4;

	localparam logic REG_DATA_BITS = 1'b0;

	localparam logic FUNC_ENCODE = 1'b0;
	localparam logic FUNC_CHECK  = 1'b1;

	typedef logic [CODE_W-1:0] code_t;
	typedef logic [LEN_W-1:0]  len_t;
	typedef logic [SYN_W-1:0]  syn_t;

	function automatic int parity_count(input int k);
		int r;
		r = 0;
		for (int i = 0; i < 8; i++) begin
			if ((1 << r) < k + r + 1) begin
				r = r + 1;
			end
		end
		return r;
	endfunction

	function automatic int max_data_bits(input int max_code);
		int top;
		top = 1;
		for (int k = 1; k <= DATA_BITS_LIMIT; k++) begin
			if (k + parity_count(k) <= max_code) begin
				top = k;
			end
		end
		return top;
	endfunction

	function automatic code_t spread_data(input logic [DATA_W-1:0] d);
		code_t w;
		int    j;
		w = '0;
		j = 0;
		for (int p = 1; p <= CODE_W; p++) begin
			if ((p & (p - 1)) != 0) begin
				w[p-1] = d[j];
				j = j + 1;
			end
		end
		return w;
	endfunction

	function automatic code_t check_mask(input int m);
		code_t w;
		w = '0;
		for (int p = 1; p <= CODE_W; p++) begin
			if ((p & (1 << m)) != 0) begin
				w[p-1] = 1'b1;
			end
		end
		return w;
	endfunction

endpackage

// ----- src/hsec_syndrome.sv -----
// Parity-check tree giving the Hamming syndrome of a 64-bit codeword.
module hsec_syndrome
	import hsec_pkg::*;
(
	input  code_t word,
	output syn_t  syn
);

	always_comb begin
		for (int m = 0; m < SYN_W; m++) begin
			syn[m] = ^(word & check_mask(m));
		end
	end

endmodule

// ----- src/hamming_sec_encode_check.sv -----
// Hamming SEC encoder and checker: three-stage pipeline with an APB register port.
//
// One transaction can enter on every clock while item_ready is high. Its result is valid
// on the outputs once it has passed the three register stages (s1, s2, s3). A full
// pipeline sustains one result per cycle while result_ready stays high. While the result
// channel stalls, empty stages keep filling, so item_ready drops only once all three
// stages hold a transaction; a full stage holds in place until the stage after it frees
// up. Stage 1 places the data bits (or masks the received word) to the codeword length,
// stage 2 runs the parity-check trees, stage 3 sets parity bits or corrects the named
// bit. The data_bits register (byte address 0) sets the codeword length; 0 counts as one
// data bit and lengths past MAX_CODE_BITS saturate. Write it only while idle.
module hamming_sec_encode_check
	import hsec_pkg::*;
#(
	parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	input  logic                  item_valid,
	output logic                  item_ready,
	input  logic                  func,
	input  logic [DATA_W-1:0]     data_word,
	input  logic [CODE_W-1:0]     received_code,
	output logic                  result_valid,
	input  logic                  result_ready,
	output logic [CODE_W-1:0]     code_word,
	output logic [LEN_W-1:0]      code_length,
	output logic [SYN_W-1:0]      syndrome,
	output logic                  error_found,
	output logic [LEN_W-1:0]      display_position,
	output logic                  syndrome_out_of_range
);

	localparam int TOP_DATA_BITS = max_data_bits(MAX_CODE_BITS);

	logic [CFG_W-1:0] data_bits_q;
	logic [CFG_W-1:0] k_eff;
	len_t             n_cur;
	code_t            nmask;
	code_t            word_in;

	logic  valid_s1, valid_s2, valid_s3;
	logic  en_s1, en_s2, en_s3;
	logic  func_s1, func_s2;
	code_t word_s1, word_s2, word_s3;
	len_t  n_s1, n_s2, n_s3;
	syn_t  syn_s2, syn_s3;
	logic  found_s3, oor_s3;
	len_t  disp_s3;

	syn_t  syn_calc;
	code_t word_fin;
	syn_t  syn_fin;
	logic  found_fin, oor_fin;
	len_t  disp_fin;

	// configuration port
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_bits_q <= DATA_BITS_RESET;
		end else if (psel && penable && pwrite && paddr[2] == REG_DATA_BITS) begin
			data_bits_q <= pwdata[CFG_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_DATA_BITS) begin
			prdata[CFG_W-1:0] = data_bits_q;
		end
	end

	// codeword length
	always_comb begin
		k_eff = data_bits_q;
		if (k_eff == '0) begin
			k_eff = CFG_W'(1);
		end
		if (int'(k_eff) > TOP_DATA_BITS) begin
			k_eff = CFG_W'(TOP_DATA_BITS);
		end
		n_cur = LEN_W'(k_eff) + LEN_W'(parity_count(int'(k_eff)));
		nmask = ~({CODE_W{1'b1}} << n_cur);
		word_in = (func == FUNC_ENCODE) ? spread_data(data_word) : received_code;
		word_in = word_in & nmask;
	end

	// stall control
	assign en_s3      = !valid_s3 || result_ready;
	assign en_s2      = !valid_s2 || en_s3;
	assign en_s1      = !valid_s1 || en_s2;
	assign item_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (en_s1) valid_s1 <= item_valid;
			if (en_s2) valid_s2 <= valid_s1;
			if (en_s3) valid_s3 <= valid_s2;
		end
	end

	// stage 1: place and mask
	always_ff @(posedge clk) begin
		if (en_s1 && item_valid) begin
			func_s1 <= func;
			word_s1 <= word_in;
			n_s1    <= n_cur;
		end
	end

	// stage 2: parity checks
	hsec_syndrome u_syndrome (
		.word (word_s1),
		.syn  (syn_calc)
	);

	always_ff @(posedge clk) begin
		if (en_s2 && valid_s1) begin
			func_s2 <= func_s1;
			word_s2 <= word_s1;
			n_s2    <= n_s1;
			syn_s2  <= syn_calc;
		end
	end

	// stage 3: set parity or correct
	always_comb begin
		word_fin  = word_s2;
		syn_fin   = '0;
		found_fin = 1'b0;
		oor_fin   = 1'b0;
		disp_fin  = '0;
		unique case (func_s2)
			FUNC_ENCODE: begin
				for (int m = 0; m < SYN_W; m++) begin
					word_fin[(1 << m) - 1] = word_s2[(1 << m) - 1] | syn_s2[m];
				end
			end
			FUNC_CHECK: begin
				syn_fin = syn_s2;
				if (syn_s2 != '0) begin
					if (syn_s2 <= n_s2) begin
						word_fin  = word_s2 ^ (code_t'(1) << (syn_s2 - SYN_W'(1)));
						found_fin = 1'b1;
						disp_fin  = n_s2 - syn_s2 + LEN_W'(1);
					end else begin
						oor_fin = 1'b1;
					end
				end
			end
			default: begin
				word_fin = word_s2;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en_s3 && valid_s2) begin
			word_s3  <= word_fin;
			n_s3     <= n_s2;
			syn_s3   <= syn_fin;
			found_s3 <= found_fin;
			disp_s3  <= disp_fin;
			oor_s3   <= oor_fin;
		end
	end

	assign result_valid          = valid_s3;
	assign code_word             = word_s3;
	assign code_length           = n_s3;
	assign syndrome              = syn_s3;
	assign error_found           = found_s3;
	assign display_position      = disp_s3;
	assign syndrome_out_of_range = oor_s3;

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 |-> !(found_s3 && oor_s3))
		else $error("correction and out-of-range flag both set");

	a_found_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && found_s3 |-> syn_s3 != '0 && syn_s3 <= n_s3)
		else $error("correction reported for syndrome outside the codeword");

	a_disp_only_on_fix: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && !found_s3 |-> disp_s3 == '0)
		else $error("display position set without a correction");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !en_s2 |=> valid_s1 && $stable(word_s1))
		else $error("stage 1 lost its transaction during a stall");

endmodule

// ----- verif/hsec_tb_pkg.sv -----
// Result type and scoreboard for the Hamming SEC encoder and checker testbench.
package hsec_tb_pkg;
	import hsec_pkg::*;

	typedef struct packed {
		code_t code_word;
		len_t  code_length;
		syn_t  syndrome;
		logic  error_found;
		len_t  display_position;
		logic  syndrome_out_of_range;
	} hsec_result_t;

	class hsec_scoreboard;
		logic [CFG_W-1:0] data_bits_reg;
		hsec_result_t     pending_results[$];
		int               mismatches;

		function new();
			data_bits_reg = DATA_BITS_RESET;
			mismatches = 0;
		endfunction

		function void write_reg(int index, logic [APB_DATA_W-1:0] value);
			if (index == 0) begin
				data_bits_reg = value[CFG_W-1:0];
			end
		endfunction

		function int check_bits(int k);
			int r;
			r = 0;
			while (r < 16 && (1 << r) < k + r + 1) begin
				r++;
			end
			return r;
		endfunction

		function int data_len();
			int k;
			int top;
			k = int'(data_bits_reg);
			top = DATA_BITS_LIMIT;
			while (top > 1 && top + check_bits(top) > MAX_CODE_BITS_DEF) begin
				top--;
			end
			if (k < 1) begin
				k = 1;
			end
			if (k > top) begin
				k = top;
			end
			return k;
		endfunction

		function int word_len();
			int k;
			k = data_len();
			return k + check_bits(k);
		endfunction

		function int parity_syndrome(code_t w, int n, int r);
			int   s;
			logic par;
			s = 0;
			for (int m = 0; m < r; m++) begin
				par = 1'b0;
				for (int p = 1; p <= n; p++) begin
					if (((p >> m) & 1) != 0) begin
						par ^= w[p-1];
					end
				end
				if (par) begin
					s |= 1 << m;
				end
			end
			return s;
		endfunction

		function hsec_result_t hamming_result(logic f, logic [DATA_W-1:0] d, code_t rc);
			hsec_result_t res;
			int           k;
			int           r;
			int           n;
			int           j;
			int           s;
			code_t        mask;
			k = data_len();
			r = check_bits(k);
			n = k + r;
			mask = (n >= CODE_W) ? {CODE_W{1'b1}} : ((64'd1 << n) - 64'd1);
			res = '0;
			if (f == FUNC_ENCODE) begin
				j = 0;
				for (int p = 1; p <= n; p++) begin
					if ((p & (p - 1)) != 0) begin
						res.code_word[p-1] = d[j];
						j++;
					end
				end
				s = parity_syndrome(res.code_word, n, r);
				for (int m = 0; m < r; m++) begin
					if (((s >> m) & 1) != 0) begin
						res.code_word[(1 << m) - 1] = 1'b1;
					end
				end
			end else begin
				res.code_word = rc & mask;
				s = parity_syndrome(res.code_word, n, r);
				res.syndrome = syn_t'(s);
				if (s != 0) begin
					if (s <= n) begin
						res.code_word[s-1] = ~res.code_word[s-1];
						res.error_found = 1'b1;
						res.display_position = len_t'(n - s + 1);
					end else begin
						res.syndrome_out_of_range = 1'b1;
					end
				end
			end
			res.code_word &= mask;
			res.code_length = len_t'(n);
			return res;
		endfunction

		function code_t codeword_for(logic [DATA_W-1:0] d);
			hsec_result_t res;
			res = hamming_result(FUNC_ENCODE, d, '0);
			return res.code_word;
		endfunction

		function void note_item(logic f, logic [DATA_W-1:0] d, code_t rc);
			pending_results.push_back(hamming_result(f, d, rc));
		endfunction

		function int pending();
			return pending_results.size();
		endfunction

		function int field_differs(string field, logic [CODE_W-1:0] want,
				logic [CODE_W-1:0] got);
			if (want === got) begin
				return 0;
			end
			$display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
			return 1;
		endfunction

		function void check_result(hsec_result_t got);
			hsec_result_t want;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %h", $time, got);
				mismatches++;
				return;
			end
			want = pending_results.pop_front();
			mismatches += field_differs("code_word", want.code_word, got.code_word);
			mismatches += field_differs("code_length", CODE_W'(want.code_length),
				CODE_W'(got.code_length));
			mismatches += field_differs("syndrome", CODE_W'(want.syndrome),
				CODE_W'(got.syndrome));
			mismatches += field_differs("error_found", CODE_W'(want.error_found),
				CODE_W'(got.error_found));
			mismatches += field_differs("display_position", CODE_W'(want.display_position),
				CODE_W'(got.display_position));
			mismatches += field_differs("syndrome_out_of_range",
				CODE_W'(want.syndrome_out_of_range), CODE_W'(got.syndrome_out_of_range));
		endfunction
	endclass

endpackage

// ----- verif/tb_top.sv -----
// Top-level testbench: drives encode and check transactions and compares every result.
module tb_top;
	import hsec_pkg::*;
	import hsec_tb_pkg::*;

	localparam logic [APB_ADDR_W-1:0] DATA_BITS_ADDR  = APB_ADDR_W'(4 * int'(REG_DATA_BITS));
	localparam logic [APB_ADDR_W-1:0] UNUSED_REG_ADDR = APB_ADDR_W'(4);

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;
	logic                  item_valid;
	logic                  item_ready;
	logic                  func;
	logic [DATA_W-1:0]     data_word;
	code_t                 received_code;
	logic                  result_valid;
	logic                  result_ready;
	code_t                 code_word;
	len_t                  code_length;
	syn_t                  syndrome;
	logic                  error_found;
	len_t                  display_position;
	logic                  syndrome_out_of_range;

	hsec_scoreboard sb = new();
	bit             send_idle;
	bit             recv_idle;
	bit             hold_off_req;

	hamming_sec_encode_check DUT (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5000000;
		$display("hamming_sec_encode_check regression: fail");
		$finish;
	end

	function automatic int idle_len(bit enabled);
		int roll;
		if (!enabled) begin
			return 0;
		end
		roll = $urandom_range(0, 99);
		if (roll < 55) begin
			return 0;
		end
		if (roll < 93) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	function automatic code_t rand_word();
		return {$urandom, $urandom};
	endfunction

	task automatic send_item(logic f, logic [DATA_W-1:0] d, code_t rc);
		int gap;
		gap = idle_len(send_idle);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid    <= 1'b1;
		func          <= f;
		data_word     <= d;
		received_code <= rc;
		do @(negedge clk); while (!item_ready);
		@(posedge clk);
		sb.note_item(f, d, rc);
	endtask

	task automatic send_random_item();
		int                pick;
		int                n;
		int                idx;
		logic [DATA_W-1:0] d;
		code_t             noise;
		code_t             cw;
		n = sb.word_len();
		d = DATA_W'({$urandom, $urandom});
		noise = rand_word();
		pick = $urandom_range(0, 99);
		if (pick < 40) begin
			send_item(FUNC_ENCODE, d, noise);
		end else begin
			cw = sb.codeword_for(d);
			idx = $urandom_range(0, n - 1);
			if (pick < 55) begin
				cw = cw;
			end else if (pick < 80) begin
				cw[idx] = ~cw[idx];
			end else if (pick < 88) begin
				cw[idx] = ~cw[idx];
				cw |= (noise >> n) << n;
			end else begin
				cw = noise;
			end
			send_item(FUNC_CHECK, DATA_W'(noise), cw);
		end
	endtask

	task automatic settle();
		item_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic configure(logic [APB_ADDR_W-1:0] addr, logic [CFG_W-1:0] value);
		logic [APB_DATA_W-1:0] word;
		settle();
		word = $urandom;
		word[CFG_W-1:0] = value;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= word;
		@(posedge clk);
		penable <= 1'b1;
		do @(negedge clk); while (!pready);
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		sb.write_reg(int'(addr >> 2), word);
	endtask

	initial begin : result_sink
		int stall;
		int hold;
		stall = 0;
		hold = 0;
		result_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				hold = 300;
				hold_off_req = 1'b0;
			end
			if (hold > 0) begin
				hold--;
				result_ready <= 1'b0;
			end else if (stall > 0) begin
				stall--;
				result_ready <= 1'b0;
			end else begin
				stall = idle_len(recv_idle);
				result_ready <= (stall == 0);
			end
			@(negedge clk);
			if (result_valid && result_ready) begin
				sb.check_result({code_word, code_length, syndrome, error_found,
					display_position, syndrome_out_of_range});
			end
		end
	end

	initial begin : stimulus
		code_t            cw;
		logic [CFG_W-1:0] cfg;
		arst_n        <= 1'b0;
		psel          <= 1'b0;
		penable       <= 1'b0;
		pwrite        <= 1'b0;
		paddr         <= '0;
		pwdata        <= '0;
		item_valid    <= 1'b0;
		func          <= FUNC_ENCODE;
		data_word     <= '0;
		received_code <= '0;
		send_idle    = 1'b1;
		recv_idle    = 1'b1;
		hold_off_req = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// four data bits out of reset
		send_item(FUNC_ENCODE, '0, '0);
		send_item(FUNC_ENCODE, '1, '1);
		cw = sb.codeword_for(DATA_W'(11));
		send_item(FUNC_CHECK, '0, cw);
		send_item(FUNC_CHECK, '0, cw ^ 64'h4);
		send_item(FUNC_CHECK, '1, '1);
		send_item(FUNC_CHECK, '1, '0);

		// zero reads as one data bit
		configure(DATA_BITS_ADDR, 6'd0);
		send_item(FUNC_ENCODE, DATA_W'(1), '0);
		send_item(FUNC_CHECK, '0, 64'h6);

		// syndrome beyond a five-bit codeword
		configure(DATA_BITS_ADDR, 6'd2);
		send_item(FUNC_CHECK, '0, 64'hA);
		send_item(FUNC_CHECK, '0, 64'hC);

		// write to an address past the register list
		configure(UNUSED_REG_ADDR, 6'd9);
		send_item(FUNC_ENCODE, DATA_W'(3), '0);

		// longest codeword
		configure(DATA_BITS_ADDR, 6'd57);
		send_item(FUNC_ENCODE, '1, '0);
		send_item(FUNC_ENCODE, DATA_W'(rand_word()), rand_word());
		send_item(FUNC_CHECK, '0, '1);
		cw = sb.codeword_for(DATA_W'(rand_word()));
		send_item(FUNC_CHECK, '0, cw ^ (64'd1 << 63));
		send_item(FUNC_CHECK, '0, cw ^ 64'd1);

		// oversized length saturates
		configure(DATA_BITS_ADDR, 6'd63);
		send_item(FUNC_ENCODE, '1, '1);
		send_item(FUNC_CHECK, '1, rand_word());

		for (int ph = 0; ph < 7; ph++) begin
			case (ph)
				0: cfg = CFG_W'($urandom_range(2, 56));
				1: cfg = 6'd57;
				2: cfg = 6'd1;
				3: cfg = 6'd63;
				4: cfg = CFG_W'($urandom_range(0, 63));
				5: cfg = 6'd0;
				default: cfg = CFG_W'($urandom_range(2, 56));
			endcase
			configure(DATA_BITS_ADDR, cfg);
			send_idle = (ph != 2 && ph != 3);
			recv_idle = (ph != 2);
			if (ph == 3) begin
				hold_off_req = 1'b1;
			end
			repeat (150) send_random_item();
		end

		item_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.mismatches == 0) begin
			$display("hamming_sec_encode_check regression: pass");
		end else begin
			$display("hamming_sec_encode_check regression: fail");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
src/hsec_pkg.sv
src/hsec_syndrome.sv
src/hamming_sec_encode_check.sv
verif/hsec_tb_pkg.sv
verif/tb_top.sv
